// ===== hw/rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg: shared definitions for the limit order book matcher
// Response codes, field widths and the pending response record.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int unsigned DefBookDepth = 16;

  localparam int unsigned IdW    = 32;
  localparam int unsigned PriceW = 24;
  localparam int unsigned QtyW   = 24;
  localparam int unsigned CashW  = 40;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned ArrW   = 32;
  localparam int unsigned KindW  = 3;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpCancel = 2'd1;
  localparam logic [1:0] OpModify = 2'd2;

  localparam logic [KindW-1:0] KindFilled       = 3'd0;
  localparam logic [KindW-1:0] KindPartial      = 3'd1;
  localparam logic [KindW-1:0] KindResting      = 3'd2;
  localparam logic [KindW-1:0] KindCancelled    = 3'd3;
  localparam logic [KindW-1:0] KindCancelFailed = 3'd4;
  localparam logic [KindW-1:0] KindModified     = 3'd5;
  localparam logic [KindW-1:0] KindModifyFailed = 3'd6;
  localparam logic [KindW-1:0] KindBookFull     = 3'd7;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    id;
    logic              buy;
    logic              own;
    logic [QtyW-1:0]   qty;
    logic [PriceW-1:0] price;
  } resp_t;

endpackage

// ===== hw/rtl/lobm_div.sv =====
// ----------------------------------------------------------------------------
// lobm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, cash by price.
// ----------------------------------------------------------------------------
module lobm_div
  import lobm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CashW-1:0]  dividend_i,
  input  logic [PriceW-1:0] divisor_i,
  output logic              done_o,
  output logic [CashW-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(CashW + 1);

  logic [CntW-1:0]   cnt_q;
  logic              run_q;
  logic              done_q;
  logic [CashW-1:0]  quo_q;
  logic [PriceW:0]   rem_q;
  logic [PriceW-1:0] dvs_q;
  logic [PriceW:0]   shifted;
  logic [PriceW:0]   diff;

  assign shifted = {rem_q[PriceW-1:0], quo_q[CashW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(CashW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the remainder, subtract where it fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[PriceW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[CashW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[CashW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && cnt_q > CntW'(1) |=> run_q) else $error("divider stopped early");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("divider restarted while running");

endmodule

// ===== hw/rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority order book
// Add, cancel and modify orders against a small resting table.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o low; busy_o then stays high
// until the cycle that carries the last response of that item, so the next item
// may be taken at the edge that takes that beat. Responses appear at most one
// beat per cycle on resp_valid_o and cannot be held off, so capture them as they
// come; last_o marks the final beat of an item, and an item that produces nothing
// (a zero quantity add or an unused opcode) produces no beat at all. The
// sequencer walks the table one entry per cycle: a cancel walks it once, an add
// once per trade attempt and once more for resting, and every trade with a cash
// cap goes through the shared divider (40 bits, one bit per cycle).
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = DefBookDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        opcode_i,
  input  logic [IdW-1:0]    order_id_i,
  input  logic              is_buy_i,
  input  logic              is_limit_i,
  input  logic [PriceW-1:0] price_i,
  input  logic              price_given_i,
  input  logic [QtyW-1:0]   quantity_i,
  input  logic              is_own_i,
  input  logic [CashW-1:0]  available_cash_i,
  input  logic [TimeW-1:0]  timestamp_i,
  output logic              resp_valid_o,
  output logic [KindW-1:0]  response_kind_o,
  output logic [IdW-1:0]    resp_order_id_o,
  output logic              resp_is_buy_o,
  output logic              resp_is_own_o,
  output logic [QtyW-1:0]   fill_qty_o,
  output logic [PriceW-1:0] fill_price_o,
  output logic [TimeW-1:0]  resp_time_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BOOK_DEPTH - 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StFind   = 4'd1;
  localparam logic [3:0] StFDone  = 4'd2;
  localparam logic [3:0] StCheck  = 4'd3;
  localparam logic [3:0] StScan   = 4'd4;
  localparam logic [3:0] StEval   = 4'd5;
  localparam logic [3:0] StDiv    = 4'd6;
  localparam logic [3:0] StCap    = 4'd7;
  localparam logic [3:0] StTrade  = 4'd8;
  localparam logic [3:0] StTrade2 = 4'd9;
  localparam logic [3:0] StRest   = 4'd10;
  localparam logic [3:0] StSlot   = 4'd11;
  localparam logic [3:0] StSDone  = 4'd12;
  localparam logic [3:0] StFlush  = 4'd13;

  // Book table
  logic [BOOK_DEPTH-1:0] ent_valid_q;
  logic [IdW-1:0]        ent_id_q    [BOOK_DEPTH];
  logic                  ent_buy_q   [BOOK_DEPTH];
  logic [PriceW-1:0]     ent_price_q [BOOK_DEPTH];
  logic [QtyW-1:0]       ent_qty_q   [BOOK_DEPTH];
  logic                  ent_own_q   [BOOK_DEPTH];
  logic [ArrW-1:0]       ent_arr_q   [BOOK_DEPTH];
  logic [ArrW-1:0]       arr_cnt_q;

  logic [3:0]            state_q, state_d;
  logic [IdxW-1:0]       idx_q;
  logic [BOOK_DEPTH-1:0] visited_q;

  // Latched request
  logic [1:0]        op_q;
  logic [IdW-1:0]    id_q;
  logic              buy_q, lim_q, pgiven_q, own_q;
  logic [PriceW-1:0] price_q;
  logic [QtyW-1:0]   qty_q;
  logic [CashW-1:0]  cash_q;
  logic [TimeW-1:0]  time_q;

  // Order found by id
  logic              k_v_q;
  logic [IdxW-1:0]   k_idx_q;
  logic              k_buy_q, k_own_q;
  logic [PriceW-1:0] k_price_q;

  // Best opposite entry
  logic              best_v_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [PriceW-1:0] best_price_q;
  logic [ArrW-1:0]   best_arr_q;
  logic [QtyW-1:0]   best_qty_q;
  logic [IdW-1:0]    best_id_q;
  logic              best_own_q;

  logic              slot_v_q;
  logic [IdxW-1:0]   slot_idx_q;
  logic [QtyW-1:0]   q_q;
  logic              payer_q;
  logic [CashW-1:0]  prod_q;

  // Pending response, one deep so that last can be set on the final beat
  resp_t             pend_q;
  logic              pend_v_q;
  resp_t             push;
  logic              push_en;

  logic              div_start;
  logic              div_done;
  logic [CashW-1:0]  div_quo;

  // Current scan entry
  logic              cur_cand, cur_better, price_stop;
  logic [QtyW-1:0]   min_q, cap_q;
  logic              eval_payer;

  assign cur_cand = ent_valid_q[idx_q] && (ent_buy_q[idx_q] != buy_q) && !visited_q[idx_q];

  always_comb begin
    cur_better = 1'b0;
    if (!best_v_q) begin
      cur_better = 1'b1;
    end else if (ent_price_q[idx_q] == best_price_q) begin
      cur_better = ent_arr_q[idx_q] < best_arr_q;
    end else if (buy_q) begin
      cur_better = ent_price_q[idx_q] < best_price_q;
    end else begin
      cur_better = ent_price_q[idx_q] > best_price_q;
    end
  end

  assign price_stop = lim_q && (buy_q ? (price_q < best_price_q) : (price_q > best_price_q));
  assign min_q      = (qty_q < best_qty_q) ? qty_q : best_qty_q;
  assign eval_payer = buy_q ? own_q : best_own_q;
  assign cap_q      = (div_quo < {{(CashW-QtyW){1'b0}}, q_q}) ? div_quo[QtyW-1:0] : q_q;
  assign div_start  = (state_q == StEval) && best_v_q && !price_stop && eval_payer &&
                      (best_price_q != '0);

  lobm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cash_q),
    .divisor_i  (best_price_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer and response selection
  always_comb begin
    state_d = state_q;
    push_en = 1'b0;
    push    = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (opcode_i)
            OpAdd:              state_d = StCheck;
            OpCancel, OpModify: state_d = StFind;
            default:            state_d = StIdle;
          endcase
        end
      end
      StFind:  if (idx_q == LastIdx) state_d = StFDone;
      StFDone: begin
        push_en = 1'b1;
        push.id = id_q;
        state_d = StFlush;
        if (!k_v_q) begin
          push.kind = (op_q == OpCancel) ? KindCancelFailed : KindModifyFailed;
          push.own  = own_q;
        end else begin
          push.buy = k_buy_q;
          push.own = k_own_q;
          if (op_q == OpCancel) begin
            push.kind = KindCancelled;
          end else if (qty_q == '0) begin
            push.kind = KindModifyFailed;
          end else begin
            push.kind = KindModified;
            state_d   = StCheck;
          end
        end
      end
      StCheck: state_d = (qty_q == '0) ? StRest : StScan;
      StScan:  if (idx_q == LastIdx) state_d = StEval;
      StEval: begin
        if (!best_v_q || price_stop) begin
          state_d = StRest;
        end else if (div_start) begin
          state_d = StDiv;
        end else begin
          state_d = StTrade;
        end
      end
      StDiv:   if (div_done) state_d = StCap;
      StCap: begin
        if (buy_q && div_quo == '0) begin
          state_d = StRest;
        end else if (cap_q == '0) begin
          state_d = StCheck;
        end else begin
          state_d = StTrade;
        end
      end
      StTrade: begin
        push_en    = 1'b1;
        push.kind  = (qty_q == q_q) ? KindFilled : KindPartial;
        push.id    = id_q;
        push.buy   = buy_q;
        push.own   = own_q;
        push.qty   = q_q;
        push.price = best_price_q;
        state_d    = StTrade2;
      end
      StTrade2: begin
        push_en    = 1'b1;
        push.kind  = (best_qty_q == q_q) ? KindFilled : KindPartial;
        push.id    = best_id_q;
        push.buy   = !buy_q;
        push.own   = best_own_q;
        push.qty   = q_q;
        push.price = best_price_q;
        state_d    = StCheck;
      end
      StRest:  state_d = (qty_q != '0 && lim_q) ? StSlot : StFlush;
      StSlot:  if (idx_q == LastIdx) state_d = StSDone;
      StSDone: begin
        push_en   = 1'b1;
        push.kind = slot_v_q ? KindResting : KindBookFull;
        push.id   = id_q;
        push.buy  = buy_q;
        push.own  = own_q;
        state_d   = StFlush;
      end
      StFlush: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ent_valid_q  <= '0;
      arr_cnt_q    <= '0;
      pend_v_q     <= 1'b0;
      resp_valid_o <= 1'b0;
      last_o       <= 1'b0;
    end else begin
      state_q      <= state_d;
      resp_valid_o <= 1'b0;
      last_o       <= 1'b0;
      // Drain the held beat when a newer one arrives, or on flush as last.
      if (push_en) begin
        pend_v_q     <= 1'b1;
        resp_valid_o <= pend_v_q;
      end else if (state_q == StFlush) begin
        pend_v_q     <= 1'b0;
        resp_valid_o <= pend_v_q;
        last_o       <= pend_v_q;
      end
      if (state_q == StFDone && k_v_q && (op_q == OpCancel || qty_q != '0)) begin
        ent_valid_q[k_idx_q] <= 1'b0;
      end
      if (state_q == StTrade2 && best_qty_q == q_q) begin
        ent_valid_q[best_idx_q] <= 1'b0;
      end
      if (state_q == StSDone && slot_v_q) begin
        ent_valid_q[slot_idx_q] <= 1'b1;
        arr_cnt_q               <= arr_cnt_q + 1'b1;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (push_en || state_q == StFlush) begin
      response_kind_o <= pend_q.kind;
      resp_order_id_o <= pend_q.id;
      resp_is_buy_o   <= pend_q.buy;
      resp_is_own_o   <= pend_q.own;
      fill_qty_o      <= pend_q.qty;
      fill_price_o    <= pend_q.price;
      resp_time_o     <= time_q;
    end
    if (push_en) pend_q <= push;

    unique case (state_q)
      StIdle: begin
        op_q      <= opcode_i;
        id_q      <= order_id_i;
        buy_q     <= is_buy_i;
        lim_q     <= is_limit_i;
        price_q   <= price_i;
        pgiven_q  <= price_given_i;
        qty_q     <= quantity_i;
        own_q     <= is_own_i;
        cash_q    <= available_cash_i;
        time_q    <= timestamp_i;
        idx_q     <= '0;
        k_v_q     <= 1'b0;
        visited_q <= '0;
      end
      StFind: begin
        if (!k_v_q && ent_valid_q[idx_q] && ent_id_q[idx_q] == id_q) begin
          k_v_q     <= 1'b1;
          k_idx_q   <= idx_q;
          k_buy_q   <= ent_buy_q[idx_q];
          k_own_q   <= ent_own_q[idx_q];
          k_price_q <= ent_price_q[idx_q];
        end
        idx_q <= idx_q + 1'b1;
      end
      StFDone: begin
        buy_q <= k_buy_q;
        own_q <= k_own_q;
        lim_q <= 1'b1;
        if (!pgiven_q) price_q <= k_price_q;
      end
      StCheck: begin
        idx_q    <= '0;
        best_v_q <= 1'b0;
      end
      StScan: begin
        if (cur_cand && cur_better) begin
          best_v_q     <= 1'b1;
          best_idx_q   <= idx_q;
          best_price_q <= ent_price_q[idx_q];
          best_arr_q   <= ent_arr_q[idx_q];
          best_qty_q   <= ent_qty_q[idx_q];
          best_id_q    <= ent_id_q[idx_q];
          best_own_q   <= ent_own_q[idx_q];
        end
        idx_q <= idx_q + 1'b1;
      end
      StEval: begin
        visited_q[best_idx_q] <= 1'b1;
        q_q                   <= min_q;
        payer_q               <= eval_payer;
      end
      StCap:   q_q <= cap_q;
      // When the own side pays, the cap keeps q * price within the cash, so the product fits the cash width.
      StTrade: prod_q <= {{(CashW-QtyW){1'b0}}, q_q} * {{(CashW-PriceW){1'b0}}, best_price_q};
      StTrade2: begin
        qty_q                 <= qty_q - q_q;
        ent_qty_q[best_idx_q] <= best_qty_q - q_q;
        if (payer_q) cash_q <= cash_q - prod_q;
      end
      StRest: begin
        idx_q    <= '0;
        slot_v_q <= 1'b0;
      end
      StSlot: begin
        if (!slot_v_q && !ent_valid_q[idx_q]) begin
          slot_v_q   <= 1'b1;
          slot_idx_q <= idx_q;
        end
        idx_q <= idx_q + 1'b1;
      end
      StSDone: begin
        if (slot_v_q) begin
          ent_id_q[slot_idx_q]    <= id_q;
          ent_buy_q[slot_idx_q]   <= buy_q;
          ent_price_q[slot_idx_q] <= price_q;
          ent_qty_q[slot_idx_q]   <= qty_q;
          ent_own_q[slot_idx_q]   <= own_q;
          ent_arr_q[slot_idx_q]   <= arr_cnt_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !pend_v_q) else $error("held beat left behind at idle");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && last_o |-> !busy_o) else $error("last beat while busy");
  a_fill_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StTrade |=> state_q == StTrade2) else $error("fill pair broken");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv) else $error("divider result unexpected");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the limit order book matcher
// Drives add, cancel and modify beats from a queue in random bursts, predicts
// every response with a behavioural book model and compares each result beat
// field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lobm_pkg::*;

  localparam int unsigned Depth    = DefBookDepth;
  localparam int unsigned MaxCycles = 3000000;
  localparam int unsigned TailWait  = 400;

  // One request beat as presented on the input ports.
  typedef struct {
    logic [1:0]        op;
    logic [IdW-1:0]    id;
    logic              buy;
    logic              lim;
    logic [PriceW-1:0] price;
    logic              pgiven;
    logic [QtyW-1:0]   qty;
    logic              own;
    logic [CashW-1:0]  cash;
    logic [TimeW-1:0]  ts;
  } order_req_t;

  // One expected or observed response beat.
  typedef struct {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    id;
    logic              buy;
    logic              own;
    logic [QtyW-1:0]   qty;
    logic [PriceW-1:0] price;
    logic [TimeW-1:0]  ts;
    logic              last;
  } book_resp_t;

  logic clk, rst_n;
  logic start, busy;
  logic [1:0]        opcode;
  logic [IdW-1:0]    order_id;
  logic              is_buy, is_limit, price_given, is_own;
  logic [PriceW-1:0] price;
  logic [QtyW-1:0]   quantity;
  logic [CashW-1:0]  cash;
  logic [TimeW-1:0]  tstamp;
  logic              rvalid, r_buy, r_own, r_last;
  logic [KindW-1:0]  r_kind;
  logic [IdW-1:0]    r_id;
  logic [QtyW-1:0]   r_qty;
  logic [PriceW-1:0] r_price;
  logic [TimeW-1:0]  r_time;

  order_req_t  pending_orders[$];
  book_resp_t  expected_resps[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          stim_done;
  bit          drain_req;     // hold the sender until every expected beat is back

  // Shadow book; bit storage starts cleared.
  bit              bk_valid[Depth];
  bit [IdW-1:0]    bk_id[Depth];
  bit              bk_buy[Depth];
  bit [PriceW-1:0] bk_price[Depth];
  bit [QtyW-1:0]   bk_qty[Depth];
  bit              bk_own[Depth];
  bit [ArrW-1:0]   bk_arr[Depth];
  bit [ArrW-1:0]   arr_next;

  limit_order_book_matcher i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .opcode_i        (opcode),
    .order_id_i      (order_id),
    .is_buy_i        (is_buy),
    .is_limit_i      (is_limit),
    .price_i         (price),
    .price_given_i   (price_given),
    .quantity_i      (quantity),
    .is_own_i        (is_own),
    .available_cash_i(cash),
    .timestamp_i     (tstamp),
    .resp_valid_o    (rvalid),
    .response_kind_o (r_kind),
    .resp_order_id_o (r_id),
    .resp_is_buy_o   (r_buy),
    .resp_is_own_o   (r_own),
    .fill_qty_o      (r_qty),
    .fill_price_o    (r_price),
    .resp_time_o     (r_time),
    .last_o          (r_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Append a request to the tail of the stimulus queue.
  function automatic void queue_order(input order_req_t rq);
    pending_orders.insert(pending_orders.size(), rq);
  endfunction

  function automatic void push_resp(input logic [KindW-1:0] kind, input logic [IdW-1:0] id,
                                    input logic buy, input logic own,
                                    input logic [QtyW-1:0] q, input logic [PriceW-1:0] p,
                                    input logic [TimeW-1:0] ts);
    book_resp_t r;
    r.kind = kind; r.id = id; r.buy = buy; r.own = own;
    r.qty = q; r.price = p; r.ts = ts; r.last = 1'b0;
    expected_resps.insert(expected_resps.size(), r);
  endfunction

  function automatic int find_entry(input logic [IdW-1:0] id);
    for (int i = 0; i < Depth; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Match an incoming order against the book, then rest or drop the remainder.
  function automatic void match_order(input logic [IdW-1:0] id, input logic buy,
                                      input logic lim, input logic [PriceW-1:0] lp,
                                      input logic [QtyW-1:0] qty_in, input logic own,
                                      input logic [CashW-1:0] cash_in,
                                      input logic [TimeW-1:0] ts);
    bit [Depth-1:0] visited;
    bit [QtyW-1:0]  qty;
    bit [CashW-1:0] purse;
    bit [CashW-1:0] afford;
    bit [PriceW-1:0] p;
    bit [QtyW-1:0]  q;
    bit             payer_own;
    int             best;
    int             slot;
    visited = '0;
    qty = qty_in;
    purse = cash_in;
    while (qty > 0) begin
      best = -1;
      for (int i = 0; i < Depth; i++) begin
        if (!bk_valid[i] || bk_buy[i] == buy || visited[i]) continue;
        if (best < 0) best = i;
        else if (bk_price[i] == bk_price[best]) begin
          if (bk_arr[i] < bk_arr[best]) best = i;
        end else if (buy ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best]) begin
          best = i;
        end
      end
      if (best < 0) break;
      p = bk_price[best];
      if (lim && (buy ? lp < p : lp > p)) break;
      visited[best] = 1'b1;
      q = qty < bk_qty[best] ? qty : bk_qty[best];
      payer_own = buy ? own : bk_own[best];
      if (payer_own && p != 0) begin
        afford = purse / p;
        if (buy && afford == 0) break;
        if (afford < q) q = afford[QtyW-1:0];
        if (q == 0) continue;
      end
      push_resp(qty == q ? KindFilled : KindPartial, id, buy, own, q, p, ts);
      push_resp(bk_qty[best] == q ? KindFilled : KindPartial, bk_id[best], bk_buy[best],
                bk_own[best], q, p, ts);
      qty -= q;
      bk_qty[best] -= q;
      if (payer_own) purse -= CashW'(q) * CashW'(p);
      if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
    end
    if (qty > 0 && lim) begin
      slot = -1;
      for (int i = 0; i < Depth; i++)
        if (!bk_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
        push_resp(KindBookFull, id, buy, own, '0, '0, ts);
      end else begin
        bk_valid[slot] = 1'b1; bk_id[slot] = id; bk_buy[slot] = buy;
        bk_price[slot] = lp; bk_qty[slot] = qty; bk_own[slot] = own;
        bk_arr[slot] = arr_next;
        arr_next++;
        push_resp(KindResting, id, buy, own, '0, '0, ts);
      end
    end
  endfunction

  // Work out every response beat of one accepted request.
  function automatic void predict_book(input order_req_t rq);
    int k;
    int before_n;
    before_n = expected_resps.size();
    if (rq.op == OpAdd) begin
      match_order(rq.id, rq.buy, rq.lim, rq.price, rq.qty, rq.own, rq.cash, rq.ts);
    end else if (rq.op == OpCancel) begin
      k = find_entry(rq.id);
      if (k < 0) push_resp(KindCancelFailed, rq.id, 1'b0, rq.own, '0, '0, rq.ts);
      else begin
        bk_valid[k] = 1'b0;
        push_resp(KindCancelled, rq.id, bk_buy[k], bk_own[k], '0, '0, rq.ts);
      end
    end else if (rq.op == OpModify) begin
      k = find_entry(rq.id);
      if (k < 0) push_resp(KindModifyFailed, rq.id, 1'b0, rq.own, '0, '0, rq.ts);
      else if (rq.qty == 0) begin
        push_resp(KindModifyFailed, rq.id, bk_buy[k], bk_own[k], '0, '0, rq.ts);
      end else begin
        bk_valid[k] = 1'b0;
        push_resp(KindModified, rq.id, bk_buy[k], bk_own[k], '0, '0, rq.ts);
        match_order(rq.id, bk_buy[k], 1'b1, rq.pgiven ? rq.price : bk_price[k], rq.qty,
                    bk_own[k], rq.cash, rq.ts);
      end
    end
    if (expected_resps.size() > before_n) expected_resps[$].last = 1'b1;
  endfunction

  // Random request; ids come from a small pool so cancels and modifies hit.
  function automatic order_req_t rand_order(input bit noise);
    order_req_t rq;
    int sel;
    sel = $urandom_range(0, 99);
    rq.op     = sel < 60 ? OpAdd : (sel < 78 ? OpCancel : (sel < 97 ? OpModify : 2'd3));
    rq.id     = noise ? $urandom : 32'(32'h100 + $urandom_range(0, 23));
    rq.buy    = $urandom_range(0, 1);
    rq.lim    = $urandom_range(0, 4) != 0;
    rq.price  = noise ? 24'($urandom_range(1, 24'hFFFFFF))
                      : 24'(1000 + $urandom_range(0, 12) * 5);
    rq.pgiven = $urandom_range(0, 1);
    rq.qty    = noise ? 24'($urandom) : 24'($urandom_range(0, 40) == 0 ? 0
                                               : $urandom_range(1, 300));
    rq.own    = $urandom_range(0, 2) == 0;
    rq.cash   = $urandom_range(0, 3) == 0 ? 40'($urandom_range(0, 4000))
                                          : {8'($urandom), 32'($urandom)};
    rq.ts     = {16'($urandom), 32'($urandom)};
    return rq;
  endfunction

  function automatic order_req_t mk_order(input logic [1:0] op, input logic [IdW-1:0] id,
                                          input logic buy, input logic lim,
                                          input logic [PriceW-1:0] p, input logic pg,
                                          input logic [QtyW-1:0] q, input logic own,
                                          input logic [CashW-1:0] c);
    order_req_t rq;
    rq.op = op; rq.id = id; rq.buy = buy; rq.lim = lim; rq.price = p;
    rq.pgiven = pg; rq.qty = q; rq.own = own; rq.cash = c;
    rq.ts = {16'($urandom), 32'($urandom)};
    return rq;
  endfunction

  // Fill the stimulus queue: directed corner cases first, then random traffic.
  initial begin
    order_req_t rq;
    stim_done = 1'b0; drain_req = 1'b0;
    // Unknown cancel and modify, zero quantity add, unused opcode.
    queue_order(mk_order(OpCancel, 32'hFFFF_FFFF, 1, 1, 1, 0, 1, 1, '0));
    queue_order(mk_order(OpModify, 32'h0, 1, 1, 1, 1, 5, 0, '0));
    queue_order(mk_order(OpAdd, 32'h1, 1, 1, 100, 0, 0, 0, '0));
    queue_order(mk_order(2'd3, 32'h2, 1, 1, 100, 1, 9, 1, '1));
    // Two asks at one price and a better one; a buy takes them by price then time.
    queue_order(mk_order(OpAdd, 32'h10, 0, 1, 24'hFFFFFF, 0, 24'hFFFFFF, 0, 0));
    queue_order(mk_order(OpAdd, 32'h11, 0, 1, 200, 0, 10, 1, 0));
    queue_order(mk_order(OpAdd, 32'h12, 0, 1, 200, 0, 10, 0, 0));
    queue_order(mk_order(OpAdd, 32'h13, 0, 1, 150, 0, 5, 0, 0));
    // Own buy with cash for only some units; then one with no cash at all.
    queue_order(mk_order(OpAdd, 32'h14, 1, 1, 200, 0, 30, 1, 40'd2150));
    queue_order(mk_order(OpAdd, 32'h15, 1, 0, 300, 0, 10, 1, 40'd0));
    // Market buy takes what is left of the top ask; a market remainder never rests.
    queue_order(mk_order(OpAdd, 32'h16, 1, 0, 1, 0, 3, 0, '1));
    // Own resting bid hit by a sell with zero cash: skipped.
    queue_order(mk_order(OpAdd, 32'h17, 1, 1, 100, 0, 8, 1, 0));
    queue_order(mk_order(OpAdd, 32'h18, 1, 1, 90, 0, 8, 0, 0));
    queue_order(mk_order(OpAdd, 32'h19, 0, 0, 1, 0, 12, 0, 40'd0));
    // Modify keeping and replacing the price, zero quantity modify, cancel.
    queue_order(mk_order(OpModify, 32'h17, 0, 0, 5, 0, 4, 0, 40'd1000));
    queue_order(mk_order(OpModify, 32'h10, 0, 0, 95, 1, 2, 1, 40'd1000));
    queue_order(mk_order(OpModify, 32'h17, 0, 0, 5, 0, 0, 0, 0));
    queue_order(mk_order(OpCancel, 32'h17, 1, 1, 5, 0, 0, 0, 0));
    // Fill the book to force book_full.
    for (int i = 0; i < Depth + 2; i++)
      queue_order(mk_order(OpAdd, 32'h40 + i, 1, 1, 24'(10 + i), 0, 1, i[0], 0));
    // Wait until the directed part is through, drain, then clear the book.
    wait (pending_orders.size() == 0);
    drain_req = 1'b1;
    wait (expected_resps.size() == 0 && !busy);
    drain_req = 1'b0;
    for (int i = 0; i < Depth + 4; i++)
      queue_order(mk_order(OpCancel, 32'h40 + i, 0, 0, 1, 0, 0, 0, 0));
    queue_order(mk_order(OpCancel, 32'h10, 0, 0, 1, 0, 0, 0, 0));
    queue_order(mk_order(OpCancel, 32'h18, 0, 0, 1, 0, 0, 0, 0));
    for (int i = 0; i < 120; i++) begin
      rq = rand_order($urandom_range(0, 9) == 0);
      queue_order(rq);
      if (i == 60) begin
        wait (pending_orders.size() == 0);
        drain_req = 1'b1;
        wait (expected_resps.size() == 0 && !busy);
        drain_req = 1'b0;
      end
    end
    wait (pending_orders.size() == 0);
    stim_done = 1'b1;
  end

  // Reset sequence.
  int unsigned burst_left, gap_left;
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Accept at the rising edge; the prediction runs when the beat is taken.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_book('{opcode, order_id, is_buy, is_limit, price, price_given,
                     quantity, is_own, cash, tstamp});
      void'(pending_orders.pop_front());
    end
  end

  // Driver: present items at the falling edge in bursts with random gaps.
  always @(negedge clk) begin
    order_req_t nx;
    if (!rst_n) begin
      start <= 1'b0;
      opcode <= '0; order_id <= '0; is_buy <= 1'b0; is_limit <= 1'b0; price <= '0;
      price_given <= 1'b0; quantity <= '0; is_own <= 1'b0; cash <= '0; tstamp <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_orders.size() > 0 && !drain_req && !busy) begin
        nx = pending_orders[0];
        start <= 1'b1;
        opcode <= nx.op; order_id <= nx.id; is_buy <= nx.buy; is_limit <= nx.lim;
        price <= nx.price; price_given <= nx.pgiven; quantity <= nx.qty;
        is_own <= nx.own; cash <= nx.cash; tstamp <= nx.ts;
        if (burst_left == 0) begin
          // End of burst: pick a fresh length and an idle gap, often none.
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each response beat with the oldest expectation.
  always @(posedge clk) begin
    book_resp_t exp_r;
    if (rst_n && rvalid) begin
      if (expected_resps.size() == 0) begin
        report_mismatch($sformatf("unexpected response kind %0d id %h", r_kind, r_id));
      end else begin
        exp_r = expected_resps.pop_front();
        if (r_kind !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, want %0d", r_kind, exp_r.kind));
        if (r_id !== exp_r.id)
          report_mismatch($sformatf("order id %h, want %h", r_id, exp_r.id));
        if (r_buy !== exp_r.buy)
          report_mismatch($sformatf("is_buy %b, want %b", r_buy, exp_r.buy));
        if (r_own !== exp_r.own)
          report_mismatch($sformatf("is_own %b, want %b", r_own, exp_r.own));
        if (r_qty !== exp_r.qty)
          report_mismatch($sformatf("fill qty %0d, want %0d", r_qty, exp_r.qty));
        if (r_price !== exp_r.price)
          report_mismatch($sformatf("fill price %0d, want %0d", r_price, exp_r.price));
        if (r_time !== exp_r.ts)
          report_mismatch($sformatf("time %h, want %h", r_time, exp_r.ts));
        if (r_last !== exp_r.last)
          report_mismatch($sformatf("last %b, want %b", r_last, exp_r.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // End of run: drain, allow a tail for stray beats, then judge.
  initial begin
    wait (stim_done);
    wait (expected_resps.size() == 0 && !busy && !start);
    repeat (TailWait) @(posedge clk);
    if (expected_resps.size() != 0) report_mismatch("responses still outstanding");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_div.sv
hw/rtl/limit_order_book_matcher.sv
tb/testbench.sv
